>>> hdl/lidar_frame_receiver_xor_check_top_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the lidar frame receiver
// Shared property templates used by the top level checks.
// ----------------------------------------------------------------------------
`ifndef LIDAR_FRAME_RECEIVER_XOR_CHECK_TOP_DEFINES_SVH
`define LIDAR_FRAME_RECEIVER_XOR_CHECK_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define LFRX_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define LFRX_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/lfrx_pkg.sv
// ----------------------------------------------------------------------------
// lfrx_pkg
// Widths, register codes and shared structs of the frame receiver.
// ----------------------------------------------------------------------------
package lfrx_pkg;

  localparam int ByteW          = 8;
  localparam int NibW           = 4;
  localparam int PosW           = 6;
  localparam int PosSlots       = 2 ** PosW;
  localparam int BankCount      = 2;
  localparam int AddrW          = PosW + 1;
  localparam int CfgIdxW        = 2;
  localparam int FrameLengthDef = 60;

  // Configuration register indexes.
  localparam logic [CfgIdxW-1:0] CfgFirstHdr  = CfgIdxW'(0);
  localparam logic [CfgIdxW-1:0] CfgSecondHdr = CfgIdxW'(1);

  // Header nibble reset values.
  localparam logic [NibW-1:0] FirstHdrRst  = NibW'(10);
  localparam logic [NibW-1:0] SecondHdrRst = NibW'(5);

  // Receive positions with a role of their own.
  localparam logic [PosW-1:0] FirstHdrPos  = PosW'(0);
  localparam logic [PosW-1:0] SecondHdrPos = PosW'(1);
  localparam logic [PosW-1:0] FirstBodyPos = PosW'(2);

  // Frame store write port.
  typedef struct packed {
    logic             en;
    logic [AddrW-1:0] addr;
    logic [ByteW-1:0] data;
  } ram_wr_t;

  // A bank handed over between front and back (frame token or release).
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_msg_t;

  // Replay engine status.
  typedef struct packed {
    logic active;
    logic bank;
  } back_stat_t;

endpackage

>>> hdl/lfrx_ram.sv
// ----------------------------------------------------------------------------
// lfrx_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module lfrx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 128,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write port and registered read port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/lfrx_queue.sv
// ----------------------------------------------------------------------------
// lfrx_queue
// Two-entry queue of finished frame tokens between receiver and replay.
// ----------------------------------------------------------------------------
module lfrx_queue import lfrx_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  bank_msg_t push_i,
  input  logic      pop_i,
  output logic      empty_o,
  output logic      full_o,
  output logic      head_o
);

  logic [1:0] ent_q;
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] count_q, count_d;
  logic       do_push, do_pop;

  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign head_o  = ent_q[rd_ptr_q];
  assign do_push = push_i.valid && !full_o;
  assign do_pop  = pop_i && !empty_o;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_d = wr_ptr_q ^ do_push;
    rd_ptr_d = rd_ptr_q ^ do_pop;
    count_d  = count_q + {1'b0, do_push} - {1'b0, do_pop};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Token storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wr_ptr_q] <= push_i.bank;
    end
  end

endmodule

>>> hdl/lfrx_front.sv
// ----------------------------------------------------------------------------
// lfrx_front
// Receiver: hunts headers, stores frame words, checks the XOR and hands
// good frames to the replay side by bank.
// ----------------------------------------------------------------------------
module lfrx_front import lfrx_pkg::*; #(
  parameter int FRAME_LENGTH = FrameLengthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             rx_valid_i,
  output logic             rx_ready_o,
  input  logic [ByteW-1:0] rx_byte_i,
  input  logic [NibW-1:0]  hdr0_i,
  input  logic [NibW-1:0]  hdr1_i,
  input  bank_msg_t        release_i,
  output bank_msg_t        push_o,
  output ram_wr_t          ram_wr_o
);

  localparam logic [PosW-1:0] LastPos = PosW'(FRAME_LENGTH - 1);

  logic [PosW-1:0]      pos_q, pos_d;
  logic [ByteW-1:0]     xor_q, xor_d;
  logic [NibW-1:0]      nib0_q, nib0_d;
  logic [NibW-1:0]      nib1_q, nib1_d;
  logic                 wr_bank_q, wr_bank_d;
  logic [BankCount-1:0] busy_q, busy_d;
  logic                 accept;
  logic [NibW-1:0]      hi_nib, lo_nib;
  logic [ByteW-1:0]     xor_next;
  logic                 good;

  // A word is taken only while the bank being filled is not locked by a good frame still to be replayed.
  assign rx_ready_o = !busy_q[wr_bank_q];
  assign accept     = rx_valid_i && rx_ready_o;
  assign hi_nib     = rx_byte_i[ByteW-1 -: NibW];
  assign lo_nib     = rx_byte_i[NibW-1:0];
  assign xor_next   = ((pos_q == FirstBodyPos) ? '0 : xor_q) ^ rx_byte_i;

  // Position tracking, header checks and the running XOR.
  always_comb begin
    pos_d         = pos_q;
    xor_d         = xor_q;
    nib0_d        = nib0_q;
    nib1_d        = nib1_q;
    good          = 1'b0;
    ram_wr_o.en   = 1'b0;
    ram_wr_o.addr = {wr_bank_q, pos_q};
    ram_wr_o.data = rx_byte_i;
    if (accept) begin
      priority if (pos_q == FirstHdrPos) begin
        if (hi_nib == hdr0_i) begin
          ram_wr_o.en = 1'b1;
          nib0_d      = lo_nib;
          pos_d       = SecondHdrPos;
        end
      end else if (pos_q == SecondHdrPos) begin
        if (hi_nib == hdr1_i) begin
          ram_wr_o.en = 1'b1;
          nib1_d      = lo_nib;
          pos_d       = FirstBodyPos;
        end else begin
          pos_d = FirstHdrPos;
        end
      end else if (pos_q != LastPos) begin
        ram_wr_o.en = 1'b1;
        xor_d       = xor_next;
        pos_d       = pos_q + PosW'(1);
      end else begin
        ram_wr_o.en = 1'b1;
        xor_d       = xor_next;
        pos_d       = FirstHdrPos;
        good        = (xor_next == {nib1_q, nib0_q});
      end
    end
  end

  // Bank ownership: a good frame locks its bank until replay has read it.
  always_comb begin
    busy_d    = busy_q;
    wr_bank_d = wr_bank_q;
    if (release_i.valid) begin
      busy_d[release_i.bank] = 1'b0;
    end
    if (good) begin
      busy_d[wr_bank_q] = 1'b1;
      wr_bank_d         = !wr_bank_q;
    end
  end

  assign push_o.valid = good;
  assign push_o.bank  = wr_bank_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q     <= FirstHdrPos;
      xor_q     <= '0;
      wr_bank_q <= 1'b0;
      busy_q    <= '0;
    end else begin
      pos_q     <= pos_d;
      xor_q     <= xor_d;
      wr_bank_q <= wr_bank_d;
      busy_q    <= busy_d;
    end
  end

  // Expected check nibbles taken from the header words.
  always_ff @(posedge clk_i) begin
    nib0_q <= nib0_d;
    nib1_q <= nib1_d;
  end

endmodule

>>> hdl/lfrx_back.sv
// ----------------------------------------------------------------------------
// lfrx_back
// Replay engine: takes a frame token, reads its bank word by word and
// presents each word with its position and a last mark.
// ----------------------------------------------------------------------------
module lfrx_back import lfrx_pkg::*; #(
  parameter int FRAME_LENGTH = FrameLengthDef
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             q_empty_i,
  input  logic             q_head_i,
  output logic             q_pop_o,
  output logic             ram_re_o,
  output logic [AddrW-1:0] ram_raddr_o,
  input  logic [ByteW-1:0] ram_rdata_i,
  output bank_msg_t        release_o,
  output back_stat_t       stat_o,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output logic [ByteW-1:0] frame_byte_o,
  output logic [PosW-1:0]  byte_position_o,
  output logic             last_of_frame_o
);

  localparam logic [PosW-1:0] LastPos = PosW'(FRAME_LENGTH - 1);

  typedef enum logic {
    BkIdle,
    BkRun
  } back_state_e;

  back_state_e     state_q;
  logic            bank_q;
  logic [PosW-1:0] pos_q;
  logic            pend_q;
  logic            out_valid_q;
  logic [PosW-1:0] out_pos_q;
  logic            out_last_q;
  logic            issue;
  logic            last_issue;

  // A read goes out only when the output register is free by the time
  // the data returns.
  assign issue      = (state_q == BkRun) && !pend_q && (!out_valid_q || out_ready_i);
  assign last_issue = issue && (pos_q == LastPos);
  assign q_pop_o    = (state_q == BkIdle) && !q_empty_i;

  assign ram_re_o        = issue;
  assign ram_raddr_o     = {bank_q, pos_q};
  assign release_o.valid = last_issue;
  assign release_o.bank  = bank_q;
  assign stat_o.active   = (state_q == BkRun);
  assign stat_o.bank     = bank_q;

  assign out_valid_o     = out_valid_q;
  assign frame_byte_o    = ram_rdata_i;
  assign byte_position_o = out_pos_q;
  assign last_of_frame_o = out_last_q;

  // Sequencer and output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BkIdle;
      bank_q      <= 1'b0;
      pos_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_pos_q   <= '0;
      out_last_q  <= 1'b0;
    end else begin
      pend_q <= issue;
      if (pend_q) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (issue) begin
        out_pos_q  <= pos_q;
        out_last_q <= (pos_q == LastPos);
      end
      unique case (state_q)
        BkIdle: begin
          if (!q_empty_i) begin
            bank_q  <= q_head_i;
            pos_q   <= '0;
            state_q <= BkRun;
          end
        end
        BkRun: begin
          if (last_issue) begin
            state_q <= BkIdle;
          end else if (issue) begin
            pos_q <= pos_q + PosW'(1);
          end
        end
        default: state_q <= BkIdle;
      endcase
    end
  end

endmodule

>>> hdl/lidar_frame_receiver_xor_check_top.sv
// A good frame's token goes through the token queue and the replay sequencer before the first
// word is read. Replay: each word passes the registered frame store read, then the output
// register; a new read goes out only once the last one has returned and the output is free.
// Input: one word per cycle; it stalls only while both store banks hold unplayed frames.
// Reset clears positions, the XOR, bank ownership and the token queue; the store is not cleared.
// ----------------------------------------------------------------------------
// lidar_frame_receiver_xor_check_top
// Frame receiver with header search, XOR check and replay of good frames.
// ----------------------------------------------------------------------------
`include "lidar_frame_receiver_xor_check_top_defines.svh"

module lidar_frame_receiver_xor_check_top import lfrx_pkg::*; #(
  parameter int FRAME_LENGTH = FrameLengthDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [CfgIdxW-1:0] cfg_index_i,
  input  logic [NibW-1:0]    cfg_data_i,
  input  logic               rx_valid_i,
  output logic               rx_ready_o,
  input  logic [ByteW-1:0]   rx_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [ByteW-1:0]   frame_byte_o,
  output logic [PosW-1:0]    byte_position_o,
  output logic               last_of_frame_o
);

  logic [NibW-1:0]  hdr0_q, hdr1_q;
  bank_msg_t        push;
  bank_msg_t        release_msg;
  back_stat_t       back_stat;
  ram_wr_t          ram_wr;
  logic             q_empty, q_full, q_head, q_pop;
  logic             ram_re;
  logic [AddrW-1:0] ram_raddr;
  logic [ByteW-1:0] ram_rdata;

  // Header configuration registers.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr0_q <= FirstHdrRst;
      hdr1_q <= SecondHdrRst;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == CfgFirstHdr) begin
        hdr0_q <= cfg_data_i;
      end
      if (cfg_index_i == CfgSecondHdr) begin
        hdr1_q <= cfg_data_i;
      end
    end
  end

  // Receiver side.
  lfrx_front #(
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rx_valid_i(rx_valid_i),
    .rx_ready_o(rx_ready_o),
    .rx_byte_i (rx_byte_i),
    .hdr0_i    (hdr0_q),
    .hdr1_i    (hdr1_q),
    .release_i (release_msg),
    .push_o    (push),
    .ram_wr_o  (ram_wr)
  );

  // Two banks of frame storage.
  lfrx_ram #(
    .WIDTH(ByteW),
    .DEPTH(BankCount * PosSlots)
  ) u_store (
    .clk_i  (clk_i),
    .we_i   (ram_wr.en),
    .waddr_i(ram_wr.addr),
    .wdata_i(ram_wr.data),
    .re_i   (ram_re),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Finished frame tokens.
  lfrx_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (q_pop),
    .empty_o(q_empty),
    .full_o (q_full),
    .head_o (q_head)
  );

  // Replay side.
  lfrx_back #(
    .FRAME_LENGTH(FRAME_LENGTH)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .q_empty_i      (q_empty),
    .q_head_i       (q_head),
    .q_pop_o        (q_pop),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .release_o      (release_msg),
    .stat_o         (back_stat),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_byte_o   (frame_byte_o),
    .byte_position_o(byte_position_o),
    .last_of_frame_o(last_of_frame_o)
  );

  // Checks on bank handover between the two sides.
  `LFRX_ASSERT_IMP(a_push_not_full, clk_i, rst_ni, push.valid, !q_full,
                   "frame token pushed into a full queue")
  `LFRX_ASSERT_IMP(a_no_write_under_replay, clk_i, rst_ni,
                   ram_wr.en && back_stat.active,
                   ram_wr.addr[AddrW-1] != back_stat.bank,
                   "receiver wrote into the bank under replay")
  `LFRX_ASSERT_NXT(a_pop_starts_replay, clk_i, rst_ni, q_pop,
                   back_stat.active && (back_stat.bank == $past(q_head)),
                   "replay did not start on the popped bank")

endmodule

>>> tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Frame receiver testbench
// Sends header searches, a good frame and a frame with a bad XOR check into
// the receiver under reset and programmed headers and several idling patterns.
// A model of the receiver predicts each replayed word, and a checker
// compares every replayed word with the oldest prediction.
// ----------------------------------------------------------------------------
module testbench;
  import lfrx_pkg::*;

  // The block runs at its default frame length.
  localparam int FrameLen    = FrameLengthDef;
  localparam int DrainCycles = 2 * FrameLen + 16;
  localparam int CycleLimit  = 200000;

  // Register indexes that the block does not implement.
  localparam logic [CfgIdxW-1:0] CfgSpareLo = CfgIdxW'(2);
  localparam logic [CfgIdxW-1:0] CfgSpareHi = CfgIdxW'(3);

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic [PosW-1:0]  pos;
    logic             last;
  } frame_word_t;

  logic               clk_i = 1'b0;
  logic               rst_ni;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [CfgIdxW-1:0] cfg_index_i;
  logic [NibW-1:0]    cfg_data_i;
  logic               rx_valid_i;
  logic               rx_ready_o;
  logic [ByteW-1:0]   rx_byte_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic [ByteW-1:0]   frame_byte_o;
  logic [PosW-1:0]    byte_position_o;
  logic               last_of_frame_o;

  // Receiver model state.
  logic [NibW-1:0]  first_hdr;
  logic [NibW-1:0]  second_hdr;
  logic [PosW-1:0]  rx_pos;
  logic [ByteW-1:0] rx_xor;
  logic [ByteW-1:0] frame_store [PosSlots];

  frame_word_t replay_words_q [$];
  frame_word_t got_word;
  frame_word_t want_word;

  int error_count   = 0;
  int cycle_count   = 0;
  int rx_gap_pct    = 0;
  int out_stall_pct = 0;

  lidar_frame_receiver_xor_check_top #(
    .FRAME_LENGTH(FrameLen)
  ) uut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .rx_valid_i     (rx_valid_i),
    .rx_ready_o     (rx_ready_o),
    .rx_byte_i      (rx_byte_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .frame_byte_o   (frame_byte_o),
    .byte_position_o(byte_position_o),
    .last_of_frame_o(last_of_frame_o)
  );

  // Free-running clock with a 2 ns period.
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // The run is cut off if it hangs.
  initial begin
    while (cycle_count < CycleLimit) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("FAIL lidar_frame_receiver_xor_check_top");
    $finish;
  end

  // Advance the receiver model by one word and queue the words of a good frame.
  function automatic void track_rx_byte(input logic [ByteW-1:0] b);
    logic [ByteW-1:0] check;
    frame_word_t w;
    if (rx_pos == FirstHdrPos) begin
      if (b[7:4] == first_hdr) begin
        frame_store[0] = b;
        rx_pos = SecondHdrPos;
      end
    end else if (rx_pos == SecondHdrPos) begin
      // A wrong second header restarts the hunt without being tried as a first one.
      if (b[7:4] == second_hdr) begin
        frame_store[1] = b;
        rx_pos = FirstBodyPos;
      end else begin
        rx_pos = FirstHdrPos;
      end
    end else if (rx_pos == FirstBodyPos) begin
      frame_store[rx_pos] = b;
      rx_xor = b;
      rx_pos = rx_pos + PosW'(1);
    end else if (rx_pos < PosW'(FrameLen - 1)) begin
      frame_store[rx_pos] = b;
      rx_xor = rx_xor ^ b;
      rx_pos = rx_pos + PosW'(1);
    end else begin
      frame_store[rx_pos] = b;
      rx_xor = rx_xor ^ b;
      rx_pos = FirstHdrPos;
      check = {frame_store[1][3:0], frame_store[0][3:0]};
      if (rx_xor == check) begin
        for (int k = 0; k < FrameLen; k++) begin
          w.data = frame_store[k];
          w.pos  = PosW'(k);
          w.last = (k == FrameLen - 1);
          replay_words_q.push_back(w);
        end
      end
    end
  endfunction

  task automatic check_field(input string name, input logic [ByteW-1:0] want,
                             input logic [ByteW-1:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endtask

  // Compare each replayed word with the oldest prediction, and stall at random.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) begin
        got_word.data = frame_byte_o;
        got_word.pos  = byte_position_o;
        got_word.last = last_of_frame_o;
        if (replay_words_q.size() == 0) begin
          $error("frame word %0h at position %0d with no word predicted",
                 frame_byte_o, byte_position_o);
          error_count++;
        end else begin
          want_word = replay_words_q.pop_front();
          check_field("frame_byte", want_word.data, got_word.data);
          check_field("byte_position", ByteW'(want_word.pos), ByteW'(got_word.pos));
          check_field("last_of_frame", ByteW'(want_word.last), ByteW'(got_word.last));
        end
      end
      out_ready_i <= ($urandom_range(99) >= out_stall_pct);
    end
  end

  // Send one received word, with a random gap first; valid stays high on return.
  task automatic send_byte(input logic [ByteW-1:0] b);
    bit lowered;
    lowered = 1'b0;
    while ($urandom_range(99) < rx_gap_pct) begin
      if (!lowered) begin
        rx_valid_i <= 1'b0;
        lowered = 1'b1;
      end
      @(posedge clk_i);
    end
    rx_valid_i <= 1'b1;
    rx_byte_i  <= b;
    do @(posedge clk_i); while (!rx_ready_o);
    track_rx_byte(b);
  endtask

  task automatic rx_stop();
    rx_valid_i <= 1'b0;
  endtask

  // Select the idling pattern of the sender and of the receiver.
  task automatic set_idling(input int gap, input int stall);
    rx_gap_pct    = gap;
    out_stall_pct = stall;
  endtask

  // Send a whole frame under the current headers; a nonzero flip spoils the check.
  task automatic send_frame(input logic [NibW-1:0] lo_first, input logic [NibW-1:0] lo_second,
                            input logic [ByteW-1:0] fill, input bit rand_body,
                            input logic [ByteW-1:0] flip);
    logic [ByteW-1:0] body_xor;
    logic [ByteW-1:0] b;
    body_xor = '0;
    send_byte({first_hdr, lo_first});
    send_byte({second_hdr, lo_second});
    for (int k = 2; k < FrameLen - 1; k++) begin
      b = rand_body ? ByteW'($urandom_range(255)) : fill;
      body_xor = body_xor ^ b;
      send_byte(b);
    end
    send_byte(body_xor ^ {lo_second, lo_first} ^ flip);
  endtask

  // Write one register; valid stays high on return.
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [NibW-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx == CfgFirstHdr) begin
      first_hdr = val;
    end else if (idx == CfgSecondHdr) begin
      second_hdr = val;
    end
  endtask

  task automatic program_headers(input logic [NibW-1:0] first, input logic [NibW-1:0] second);
    write_reg(CfgFirstHdr, first);
    write_reg(CfgSecondHdr, second);
    write_reg($urandom_range(1) ? CfgSpareLo : CfgSpareHi, NibW'($urandom_range(15)));
    cfg_valid_i <= 1'b0;
  endtask

  // Wait until every predicted word has come out, then let the block go quiet.
  task automatic wait_for_replay_drain();
    while (replay_words_q.size() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Neither word carries the reset first header.
  task automatic test_wrong_first_header();
    send_byte(8'h00);
    send_byte(8'hFF);
  endtask

  // The word that fails as second header is itself a first header and must be skipped.
  task automatic test_wrong_second_header();
    send_byte({first_hdr, 4'h1});
    send_byte({first_hdr, 4'h2});
    send_byte({second_hdr, 4'h3});
  endtask

  task automatic test_program_headers();
    rx_stop();
    wait_for_replay_drain();
    program_headers(4'h3, 4'hC);
  endtask

  // Writes to unimplemented indexes must leave the headers alone.
  task automatic test_unused_index();
    write_reg(CfgSpareLo, 4'hF);
    write_reg(CfgSpareHi, 4'h0);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic test_good_frame();
    send_frame(NibW'($urandom_range(15)), NibW'($urandom_range(15)), 8'h00, 1'b1, 8'h00);
  endtask

  // A spoiled frame arrives while the good frame is still being replayed.
  task automatic test_bad_check();
    send_frame(4'h5, 4'hA, 8'h3C, 1'b0, 8'h01);
    rx_stop();
  endtask

  task automatic test_receiver_stall();
    wait_for_replay_drain();
  endtask

  initial begin
    rst_ni      <= 1'b0;
    cfg_valid_i <= 1'b0;
    cfg_index_i <= CfgFirstHdr;
    cfg_data_i  <= '0;
    rx_valid_i  <= 1'b0;
    rx_byte_i   <= '0;
    first_hdr   = FirstHdrRst;
    second_hdr  = SecondHdrRst;
    rx_pos      = FirstHdrPos;
    rx_xor      = '0;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    set_idling(50, 0);
    test_wrong_first_header();
    test_wrong_second_header();

    set_idling(0, 0);
    test_program_headers();
    test_unused_index();
    test_good_frame();

    set_idling(28, 28);
    test_bad_check();

    set_idling(0, 50);
    test_receiver_stall();

    set_idling(0, 0);
    wait_for_replay_drain();
    if (error_count == 0) begin
      $display("PASS lidar_frame_receiver_xor_check_top");
    end else begin
      $display("FAIL lidar_frame_receiver_xor_check_top");
    end
    $finish;
  end

endmodule

>>> sim.f
+incdir+hdl
hdl/lfrx_pkg.sv
hdl/lfrx_ram.sv
hdl/lfrx_queue.sv
hdl/lfrx_front.sv
hdl/lfrx_back.sv
hdl/lidar_frame_receiver_xor_check_top.sv
tb/sv/testbench.sv
